FILE: rtl/core/kbw_pkg.sv
// Shared types, constants and coefficient table for the Kaiser-Bessel window evaluator.
package kbw_pkg;

   localparam int VAL_W     = 32;
   localparam int QUO_W     = 31;
   localparam int DIV_STEPS = 31;
   localparam int COEF_LEN  = 31;

   localparam logic [VAL_W-1:0] ONE_Q31  = 32'h8000_0000;
   localparam logic [63:0]      HALF_Q31 = 64'h0000_0000_4000_0000;

   typedef struct packed {
      logic valid;
      logic in_window;
   } kbw_ctl_type;

   typedef struct packed {
      logic             in_window;
      logic [VAL_W-1:0] value;
   } kbw_rsp_type;

   // series coefficients in Q0.32, lowest power first; zero past the table
   function automatic logic [VAL_W-1:0] kbw_coef(int k);
      logic [VAL_W-1:0] c;
      case (k)
         0:       c = 32'd11514021;
         1:       c = 32'd177560672;
         2:       c = 32'd684552183;
         3:       c = 32'd1172961673;
         4:       c = 32'd1130533954;
         5:       c = 32'd697370180;
         6:       c = 32'd298731241;
         7:       c = 32'd94016555;
         8:       c = 32'd22653960;
         9:       c = 32'd4312994;
         10:      c = 32'd665118;
         11:      c = 32'd84768;
         12:      c = 32'd9078;
         13:      c = 32'd828;
         14:      c = 32'd65;
         15:      c = 32'd4;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/core/kbw_div_stage.sv
// One quotient bit of the pipelined restoring divider.
module kbw_div_stage
   import kbw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic [VAL_W-1:0]  divisor,
   input  kbw_ctl_type       ctl_i,
   input  logic [VAL_W-1:0]  rem_i,
   input  logic [QUO_W-1:0]  quo_i,
   output kbw_ctl_type       ctl_o,
   output logic [VAL_W-1:0]  rem_o,
   output logic [QUO_W-1:0]  quo_o
);

   kbw_ctl_type      ctl_ff;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [VAL_W:0]   rem2;
   logic [VAL_W:0]   diff;
   logic             ge;

   always_comb begin
      rem2   = {rem_i, 1'b0};
      diff   = rem2 - {1'b0, divisor};
      ge     = rem2 >= {1'b0, divisor};
      rem_in = ge ? diff[VAL_W-1:0] : rem2[VAL_W-1:0];
      quo_in = {quo_i[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

FILE: rtl/core/kbw_horner_stage.sv
// One Horner step: registered multiply, then round, shift and add the coefficient.
module kbw_horner_stage
   import kbw_pkg::*;
#(
   parameter logic [31:0] COEF = 32'd0
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  kbw_ctl_type       ctl_i,
   input  logic [VAL_W-1:0]  acc_i,
   input  logic [VAL_W-1:0]  t_i,
   output kbw_ctl_type       ctl_o,
   output logic [VAL_W-1:0]  acc_o,
   output logic [VAL_W-1:0]  t_o
);

   kbw_ctl_type        ctl_mid_ff, ctl_ff;
   logic [2*VAL_W-1:0] prod_ff;
   logic [VAL_W-1:0]   t_mid_ff, t_ff;
   logic [VAL_W-1:0]   acc_ff, acc_in;
   logic [2*VAL_W-1:0] rnd;

   always_comb begin
      rnd    = prod_ff + HALF_Q31;
      acc_in = rnd[62:31] + COEF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_mid_ff <= '0;
         ctl_ff     <= '0;
      end else if (enable) begin
         ctl_mid_ff <= ctl_i;
         ctl_ff     <= ctl_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= acc_i * t_i;
         t_mid_ff <= t_i;
         acc_ff   <= acc_in;
         t_ff     <= t_mid_ff;
      end
   end

   assign ctl_o = ctl_ff;
   assign acc_o = acc_ff;
   assign t_o   = t_ff;

endmodule

FILE: rtl/core/kbw_out_buf.sv
// Output register with one skid entry; stalls the pipeline while the skid entry is full.
module kbw_out_buf
   import kbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  kbw_rsp_type in_data,
   output logic        pipe_en,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output kbw_rsp_type rsp_data
);

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   kbw_rsp_type out_ff, out_in;
   kbw_rsp_type skid_ff, skid_in;
   logic        take, push;

   always_comb begin
      take          = out_valid_ff & rsp_tready;
      push          = in_valid & ~skid_valid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_in       = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign pipe_en    = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_ff;

endmodule

FILE: rtl/core/kaiser_bessel_window_eval.sv
// Kaiser-Bessel window (alpha 2.5 pi) evaluator, fixed point, fully pipelined.
//
// Usage:
//   req_ channel: one sample position per request (signed Q16.16 in req_tdata).
//   rsp_ channel: one result per request, in order; rsp_tdata is the weight in
//     unsigned Q1.31 (0..1.0), rsp_tuser is set when the position lies inside
//     the window. Outside the window, and at its edge, the weight is zero.
//   csr_ port: csr_wr_en writes csr_wr_data into the window width (unsigned
//     Q16.16). Write it only while no request is in flight.
// Throughput: one request per cycle while req_tready is high.
// Pipeline: input stage, the 31-stage bit-per-stage divider, the squaring
//   multiplier, the t = 1 - s stage, two stages per Horner step, then the
//   output register.
// Reset: clears all valid bits, emptying the output buffers; width returns to 1.0.
// Stall: the output register and one skid entry absorb a stalled receiver;
//   req_tready drops while the skid entry is full and the whole pipeline holds.
module kaiser_bessel_window_eval
   import kbw_pkg::*;
#(
   parameter int SERIES_TERMS = 13
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] sample_position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] window_value
   output logic [0:0]  rsp_tuser,    // [0] inside_window
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int HSTEPS = SERIES_TERMS - 1;

   logic [VAL_W-1:0] width_ff;
   logic             pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 32'h0001_0000;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   // input stage: |x|, 2|x|, window edge test
   logic [VAL_W-1:0] mag;
   logic [VAL_W:0]   twice;
   kbw_ctl_type      in_ctl_ff, in_ctl_in;
   logic [VAL_W-1:0] in_rem_ff;

   always_comb begin
      mag                 = req_tdata[31] ? (~req_tdata + 32'd1) : req_tdata;
      twice               = {mag, 1'b0};
      in_ctl_in.valid     = req_tvalid;
      in_ctl_in.in_window = twice < {1'b0, width_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (pipe_en) begin
         in_ctl_ff <= in_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         in_rem_ff <= twice[VAL_W-1:0];
      end
   end

   // divider: q = floor(2|x| * 2^31 / W), valid for 2|x| < W
   kbw_ctl_type      div_ctl [DIV_STEPS+1];
   logic [VAL_W-1:0] div_rem [DIV_STEPS+1];
   logic [QUO_W-1:0] div_quo [DIV_STEPS+1];

   assign div_ctl[0] = in_ctl_ff;
   assign div_rem[0] = in_rem_ff;
   assign div_quo[0] = '0;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      kbw_div_stage u_div (
         .clock   (clock),
         .reset   (reset),
         .enable  (pipe_en),
         .divisor (width_ff),
         .ctl_i   (div_ctl[i]),
         .rem_i   (div_rem[i]),
         .quo_i   (div_quo[i]),
         .ctl_o   (div_ctl[i+1]),
         .rem_o   (div_rem[i+1]),
         .quo_o   (div_quo[i+1])
      );
   end

   // square stage
   kbw_ctl_type        sq_ctl_ff;
   logic [2*QUO_W-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff <= '0;
      end else if (pipe_en) begin
         sq_ctl_ff <= div_ctl[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq_ff <= div_quo[DIV_STEPS] * div_quo[DIV_STEPS];
      end
   end

   // t = 1 - s, with s rounded half up
   logic [2*QUO_W:0] s_rnd;
   logic [VAL_W-1:0] s_val;
   kbw_ctl_type      t_ctl_ff, t_ctl_in;
   logic [VAL_W-1:0] t_ff, t_in;

   always_comb begin
      s_rnd              = {1'b0, sq_ff} + HALF_Q31[2*QUO_W:0];
      s_val              = s_rnd[2*QUO_W:31];
      t_in               = ONE_Q31 - s_val;
      t_ctl_in.valid     = sq_ctl_ff.valid;
      t_ctl_in.in_window = sq_ctl_ff.in_window & (s_val < ONE_Q31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ctl_ff <= '0;
      end else if (pipe_en) begin
         t_ctl_ff <= t_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t_ff <= t_in;
      end
   end

   // Horner chain, highest coefficient first
   kbw_ctl_type      h_ctl [HSTEPS+1];
   logic [VAL_W-1:0] h_acc [HSTEPS+1];
   logic [VAL_W-1:0] h_t   [HSTEPS+1];

   assign h_ctl[0] = t_ctl_ff;
   assign h_acc[0] = kbw_coef(SERIES_TERMS - 1);
   assign h_t[0]   = t_ff;

   for (genvar i = 0; i < HSTEPS; i++) begin : g_horner
      kbw_horner_stage #(
         .COEF (kbw_coef(HSTEPS - 1 - i))
      ) u_horner (
         .clock  (clock),
         .reset  (reset),
         .enable (pipe_en),
         .ctl_i  (h_ctl[i]),
         .acc_i  (h_acc[i]),
         .t_i    (h_t[i]),
         .ctl_o  (h_ctl[i+1]),
         .acc_o  (h_acc[i+1]),
         .t_o    (h_t[i+1])
      );
   end

   // Q0.32 to Q1.31 with rounding, clamp to 1.0, zero outside the window
   logic [VAL_W:0]   half_sum;
   logic [VAL_W-1:0] val;
   kbw_rsp_type      fin;
   kbw_rsp_type      rsp_data;

   always_comb begin
      half_sum      = {1'b0, h_acc[HSTEPS]} + 33'd1;
      val           = half_sum[VAL_W:1];
      fin.in_window = h_ctl[HSTEPS].in_window;
      if (!h_ctl[HSTEPS].in_window) begin
         fin.value = '0;
      end else if (val > ONE_Q31) begin
         fin.value = ONE_Q31;
      end else begin
         fin.value = val;
      end
   end

   kbw_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (h_ctl[HSTEPS].valid),
      .in_data    (fin),
      .pipe_en    (pipe_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign req_tready   = pipe_en;
   assign rsp_tdata    = rsp_data.value;
   assign rsp_tuser[0] = rsp_data.in_window;

`ifndef SYNTHESIS
   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero weight outside window");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= ONE_Q31)
      else $error("weight above 1.0");

   a_inside_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata != '0)
      else $error("zero weight inside window");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("pipeline stalled with empty output");
`endif

endmodule
